// File: rtl/skl_pkg.sv
// Package for the streaming keyword lexer: token kinds, scan modes, the
// keyword table and the byte class helpers. No dependencies.
`default_nettype none

package skl_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int KW_COUNT    = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_DONE   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_SYMBOL  = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] length;
    logic [3:0]  kw_num;
    logic [7:0]  sym;
    logic        last;
  } tok_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Entry 0 is the ten-character word, given as ASCII bytes.
  localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
    80'h5359535F434F4E464947, "CLASS", "INIT", "FUNCTION", "MAIN", "PRINT", "FOR",
    "IN", "TO", "RETURN", "IF", "THEN", "BREAK"
  };
  localparam int KW_LEN [KW_COUNT] = '{10, 5, 4, 8, 4, 5, 3, 2, 2, 6, 2, 4, 5};

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7E) && !is_alpha(b) && !is_digit(b);
  endfunction

  // Character i of keyword k, counted from its first letter.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
    logic [79:0] t;
    int          sh;
    sh = 8 * (KW_LEN[k] - 1 - int'(i));
    if (sh < 0) sh = 0;
    t = KW_TEXT[k] >> sh;
    return t[7:0];
  endfunction

  // Drop every candidate that does not have byte b at position p.
  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] cand,
                                                  input logic [LENGTH_BITS-1:0] p,
                                                  input logic [7:0] b);
    logic [KW_COUNT-1:0] res;
    res = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!(33'(p) < 33'(KW_LEN[k])) || kw_char(k, p[3:0]) != b) res[k] = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [15:0] tok_len(input logic [LENGTH_BITS-1:0] r);
    logic [32:0] w;
    w = 33'(r);
    if (w > 33'h0FFFF) return 16'hFFFF;
    return w[15:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] r);
    if (&r) return r;
    return r + LENGTH_BITS'(1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/streaming_keyword_lexer_top.sv
// Streaming keyword lexer: byte-in, token-record-out tokenizer with a
// 13-entry keyword table. Depends on skl_pkg.
//
// Usage:
//   Input channel in_*: one source byte per beat on in_tdata; in_tlast set
//   marks end of input (the byte is then ignored), flushes any pending token,
//   emits the end token unless one was already emitted, and rearms the lexer.
//   Output channel out_*: one token record per beat, token kind on out_tuser;
//   out_tlast marks the last record caused by one input beat (a beat causes
//   zero, one or two records).
//   With the queue empty, a record is presented on out_* in the cycle
//   after the input beat that completes it. One input beat is taken per
//   cycle while in_tready is high; the classifier and keyword match vector
//   are registered from each accepted byte. Beats that each cause two records
//   outrun the one record per cycle output and back up through the queue.
//   Records go through a 4-entry output queue; in_tready is high while at
//   least two entries are free, so a stalled receiver backs up into the
//   input after the queue fills, and nothing is lost.
//   Reset (rst_n low, synchronous): queue empty, lexer idle between tokens,
//   all keywords candidates, length zero.
`default_nettype none

module streaming_keyword_lexer_top
  import skl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] token_length, [19:16] keyword_number,
                                       // [27:20] symbol_byte
  output logic [2:0]       out_tuser,  // [2:0] token_kind
  output logic             out_tlast   // last_of_run
);

  mode_t                  mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] run_r, run_nxt;
  logic [KW_COUNT-1:0]    cand_r, cand_nxt;

  tok_t                   q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r, count_nxt;

  logic                   in_acc, out_acc;
  logic                   flush_v, second_v;
  tok_t                   flush_tok, second_tok, first_tok, last_tok;
  logic [1:0]             n_res;
  logic [3:0]             kw_hit;
  logic                   kw_found;
  logic [7:0]             b;

  assign in_tready = count_r < QCNT_BITS'(QUEUE_DEPTH - 1);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = count_r != '0;
  assign out_acc   = out_tvalid && out_tready;
  assign b         = in_tdata;

  // Token completed by the current mode, if any
  always_comb begin
    kw_hit   = '0;
    kw_found = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand_r[k] && 33'(run_r) == 33'(KW_LEN[k])) begin
        kw_hit   = 4'(k);
        kw_found = 1'b1;
      end
    end
    flush_tok        = '0;
    flush_tok.length = tok_len(run_r);
    unique case (mode_r)
      MODE_IDENT:  flush_tok.kind = kw_found ? KIND_KEYWORD : KIND_IDENT;
      MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
      MODE_STRING: flush_tok.kind = KIND_STRING;
      default:     flush_tok.kind = KIND_END;
    endcase
    if (mode_r == MODE_IDENT && kw_found) flush_tok.kw_num = kw_hit;
  end

  // Next state and the records this beat produces
  always_comb begin
    mode_nxt   = mode_r;
    run_nxt    = run_r;
    cand_nxt   = cand_r;
    flush_v    = 1'b0;
    second_v   = 1'b0;
    second_tok = '0;
    second_tok.kind = KIND_END;
    if (in_tlast) begin
      flush_v  = mode_r == MODE_IDENT || mode_r == MODE_NUMBER || mode_r == MODE_STRING;
      second_v = mode_r != MODE_DONE;
      mode_nxt = MODE_IDLE;
      run_nxt  = '0;
      cand_nxt = '1;
    end else if (mode_r == MODE_DONE) begin
      mode_nxt = MODE_DONE;
    end else if (mode_r == MODE_STRING) begin
      if (b == CH_QUOTE || b == CH_NUL) begin
        flush_v  = 1'b1;
        mode_nxt = MODE_IDLE;
        run_nxt  = '0;
        cand_nxt = '1;
      end else begin
        run_nxt = grow(run_r);
      end
    end else if (mode_r == MODE_IDENT && is_word(b)) begin
      cand_nxt = kw_step(cand_r, run_r, b);
      run_nxt  = grow(run_r);
    end else if (mode_r == MODE_NUMBER && is_digit(b)) begin
      run_nxt = grow(run_r);
    end else begin
      flush_v  = mode_r == MODE_IDENT || mode_r == MODE_NUMBER;
      mode_nxt = MODE_IDLE;
      run_nxt  = '0;
      cand_nxt = '1;
      priority if (is_space(b)) begin
        mode_nxt = MODE_IDLE;
      end else if (is_alpha(b) || b == CH_UNDER) begin
        mode_nxt = MODE_IDENT;
        cand_nxt = kw_step('1, '0, b);
        run_nxt  = LENGTH_BITS'(1);
      end else if (is_digit(b)) begin
        mode_nxt = MODE_NUMBER;
        run_nxt  = LENGTH_BITS'(1);
      end else if (b == CH_QUOTE) begin
        mode_nxt = MODE_STRING;
      end else if (is_punct(b)) begin
        second_v          = 1'b1;
        second_tok.kind   = KIND_SYMBOL;
        second_tok.length = 16'd1;
        second_tok.sym    = b;
      end else begin
        second_v = 1'b1;
        mode_nxt = MODE_DONE;
      end
    end
  end

  always_comb begin
    n_res     = {1'b0, flush_v} + {1'b0, second_v};
    first_tok = flush_v ? flush_tok : second_tok;
    first_tok.last = n_res == 2'd1;
    last_tok  = second_tok;
    last_tok.last = 1'b1;
    count_nxt = count_r;
    if (in_acc) count_nxt = count_nxt + QCNT_BITS'(n_res);
    if (out_acc) count_nxt = count_nxt - QCNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      run_r    <= '0;
      cand_r   <= '1;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (out_acc) rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      if (in_acc) begin
        mode_r   <= mode_nxt;
        run_r    <= run_nxt;
        cand_r   <= cand_nxt;
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(n_res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) q_r[wr_ptr_r] <= first_tok;
    if (in_acc && n_res == 2'd2) q_r[wr_ptr_r + QPTR_BITS'(1)] <= last_tok;
  end

  assign out_tdata = {4'b0, q_r[rd_ptr_r].sym, q_r[rd_ptr_r].kw_num,
                      q_r[rd_ptr_r].length};
  assign out_tuser = q_r[rd_ptr_r].kind;
  assign out_tlast = q_r[rd_ptr_r].last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= QCNT_BITS'(QUEUE_DEPTH - 1)) |-> !in_tready)
    else $error("input ready with too little queue room");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode_r == MODE_DONE && !in_tlast) |=> (count_r <= $past(count_r)))
    else $error("record produced after end token");

  a_kw_only_keyword: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_KEYWORD) |-> (out_tdata[19:16] == 4'd0))
    else $error("keyword number on a non-keyword record");

endmodule

`default_nettype wire

// File: tb/streaming_keyword_lexer_top_test.sv
// Self-checking testbench for streaming_keyword_lexer_top: directed token cases, long
// tokens and a random source stream, checked against an in-bench lexer prediction.
// Depends on skl_pkg and the lexer RTL only.
`default_nettype none

module streaming_keyword_lexer_top_test;
  import skl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int          RANDOM_BEATS = 860;
  localparam logic [79:0] KW0_TEXT     = 80'h5359535F434F4E464947;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] length;
    logic [3:0]  kw_num;
    logic [7:0]  sym;
    logic        last;
  } lex_token_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  string keyword_words [KW_COUNT] = '{
    "", "CLASS", "INIT", "FUNCTION", "MAIN", "PRINT", "FOR",
    "IN", "TO", "RETURN", "IF", "THEN", "BREAK"
  };

  // lexer prediction state
  mode_t               lex_mode;
  logic [15:0]         lex_len;
  logic [KW_COUNT-1:0] lex_cand;
  lex_token_t          step_out [2];
  int                  step_n;

  lex_token_t  pending_tokens [$];
  lex_token_t  want;
  int          bad_tokens       = 0;
  int          tokens_checked   = 0;
  int          keywords_checked = 0;
  int          beats_sent       = 0;
  int          live_beats       = 0;
  int          burst_left       = 0;
  bit          fast_send        = 1'b0;
  int unsigned cycle_count      = 0;

  int          stall_mode  = 0;
  int          stall_phase = 0;
  logic [12:0] stall_pat   = 13'b1011001110001;

  streaming_keyword_lexer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
               pending_tokens.size());
      $display("streaming_keyword_lexer_top_test NOT OK");
      $finish;
    end
  end

  // byte classes
  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_num_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_ident_char(input logic [7:0] c);
    return is_letter(c) || is_num_char(c) || c == CH_UNDER;
  endfunction

  function automatic bit is_sym_char(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E && !is_letter(c) && !is_num_char(c);
  endfunction

  task automatic lex_clear();
    lex_mode = MODE_IDLE;
    lex_len  = '0;
    lex_cand = '1;
  endtask

  task automatic lex_grow();
    if (lex_len != 16'hFFFF) lex_len = lex_len + 16'd1;
  endtask

  task automatic lex_emit(input kind_t k, input logic [15:0] n, input logic [3:0] kw,
                          input logic [7:0] s);
    step_out[step_n].kind   = k;
    step_out[step_n].length = n;
    step_out[step_n].kw_num = kw;
    step_out[step_n].sym    = s;
    step_out[step_n].last   = 1'b0;
    step_n++;
  endtask

  task automatic lex_ident_char(input logic [7:0] c);
    for (int k = 0; k < KW_COUNT; k++) begin
      if (lex_cand[k]) begin
        if (int'(lex_len) >= keyword_words[k].len()) lex_cand[k] = 1'b0;
        else if (keyword_words[k][int'(lex_len)] != c) lex_cand[k] = 1'b0;
      end
    end
    lex_grow();
  endtask

  task automatic lex_flush();
    bit hit;
    hit = 1'b0;
    case (lex_mode)
      MODE_IDENT: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (!hit && lex_cand[k] && keyword_words[k].len() == int'(lex_len)) begin
            lex_emit(KIND_KEYWORD, lex_len, 4'(k), 8'h00);
            hit = 1'b1;
          end
        end
        if (!hit) lex_emit(KIND_IDENT, lex_len, 4'd0, 8'h00);
      end
      MODE_NUMBER: lex_emit(KIND_NUMBER, lex_len, 4'd0, 8'h00);
      MODE_STRING: lex_emit(KIND_STRING, lex_len, 4'd0, 8'h00);
      default: ;
    endcase
  endtask

  // Works out the records caused by one accepted beat and queues them.
  task automatic lex_predict(input logic [7:0] c, input logic eoi);
    step_n = 0;
    if (eoi) begin
      lex_flush();
      if (lex_mode != MODE_DONE) lex_emit(KIND_END, 16'd0, 4'd0, 8'h00);
      lex_clear();
    end else if (lex_mode == MODE_DONE) begin
    end else if (lex_mode == MODE_STRING) begin
      if (c == CH_QUOTE || c == CH_NUL) begin
        lex_flush();
        lex_clear();
      end else begin
        lex_grow();
      end
    end else if (lex_mode == MODE_IDENT && is_ident_char(c)) begin
      lex_ident_char(c);
    end else if (lex_mode == MODE_NUMBER && is_num_char(c)) begin
      lex_grow();
    end else begin
      lex_flush();
      lex_clear();
      if (is_blank(c)) begin
      end else if (is_letter(c) || c == CH_UNDER) begin
        lex_mode = MODE_IDENT;
        lex_ident_char(c);
      end else if (is_num_char(c)) begin
        lex_mode = MODE_NUMBER;
        lex_grow();
      end else if (c == CH_QUOTE) begin
        lex_mode = MODE_STRING;
      end else if (is_sym_char(c)) begin
        lex_emit(KIND_SYMBOL, 16'd1, 4'd0, c);
      end else begin
        lex_emit(KIND_END, 16'd0, 4'd0, 8'h00);
        lex_mode = MODE_DONE;
      end
    end
    for (int i = 0; i < step_n; i++) begin
      step_out[i].last = (i == step_n - 1);
      pending_tokens.insert(pending_tokens.size(), step_out[i]);
    end
  endtask

  // Sends one beat; returns at the accepting edge with in_tvalid still high.
  task automatic send_beat(input logic [7:0] c, input logic eoi);
    int gap;
    if (!fast_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    if (lex_mode != MODE_DONE || eoi) live_beats++;
    beats_sent++;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_predict(c, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Sender holds off until every queued record has come out.
  task automatic wait_for_tokens();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_word_char();
    if ($urandom_range(0, 4) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_symbol();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (is_letter(c) || is_num_char(c) || c == CH_QUOTE || c == CH_UNDER);
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        bad_tokens++;
        if (bad_tokens <= 10)
          $display("unexpected token: tuser %0d tdata %08h last %0d", out_tuser,
                   out_tdata, out_tlast);
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (want.kind == KIND_KEYWORD) keywords_checked++;
        if (out_tuser !== want.kind || out_tdata[15:0] !== want.length ||
            out_tdata[19:16] !== want.kw_num || out_tdata[27:20] !== want.sym ||
            out_tdata[31:28] !== 4'd0 || out_tlast !== want.last) begin
          bad_tokens++;
          if (bad_tokens <= 10)
            $display({"token mismatch: exp kind %0d len %0d kw %0d sym %02h last %0d;",
                      " got kind %0d len %0d kw %0d sym %02h pad %0d last %0d"},
                     want.kind, want.length, want.kw_num, want.sym, want.last,
                     out_tuser, out_tdata[15:0], out_tdata[19:16], out_tdata[27:20],
                     out_tdata[31:28], out_tlast);
        end
      end
    end
  end

  // receiver stall patterns, switched at random
  always @(posedge clk) begin
    stall_pat <= {stall_pat[0], stall_pat[12:1]};
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(50, 400);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= stall_pat[0];
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // keyword ended by a symbol, number ended by a symbol
  task automatic test_adjacent_tokens();
    send_text("IF+12;");
    wait_for_tokens();
  endtask

  // closed string with a control byte, string ended by NUL, unclosed string at end of input
  task automatic test_strings();
    send_beat(CH_QUOTE, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    send_beat(8'h7A, 1'b0);
    send_beat(CH_NUL, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    send_beat(8'hFF, 1'b1);
    wait_for_tokens();
  endtask

  // terminating bytes, dropped bytes after them, end of input with and without an end token
  task automatic test_terminators();
    send_text("_9");
    send_beat(8'hFF, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(CH_NUL, 1'b0);
    send_beat(8'hA5, 1'b1);
    send_beat(8'h00, 1'b1);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h0C, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h0C, 1'b0);
    send_beat(CH_NUL, 1'b0);
    send_beat(8'h00, 1'b1);
    wait_for_tokens();
  endtask

  // identifier with a keyword prefix, number and string, all far past keyword length
  task automatic test_long_tokens();
    fast_send = 1'b1;
    send_text("RETURN");
    repeat (54) send_beat(pick_word_char(), 1'b0);
    send_beat(8'h20, 1'b0);
    repeat (40) send_beat(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    send_beat(8'h3B, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    repeat (60) send_beat(pick_text_byte(), 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    fast_send = 1'b0;
    wait_for_tokens();
  endtask

  // mostly well-formed token sequences with random content, plus noise and terminators
  task automatic test_random_stream();
    int    start;
    int    pick;
    int    r;
    string w;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        w = keyword_words[$urandom_range(0, KW_COUNT - 1)];
        r = $urandom_range(0, 7);
        if (r == 0 && w.len() > 1) w = w.substr(0, w.len() - 2);
        if (r == 1) begin
          r = $urandom_range(0, w.len() - 1);
          if (is_letter(w[r])) w[r] = w[r] ^ 8'h20;
        end
        send_text(w);
        if ($urandom_range(0, 7) == 0) send_beat(pick_word_char(), 1'b0);
      end else if (pick < 40) begin
        send_beat(pick_letter(), 1'b0);
        repeat ($urandom_range(0, 9)) send_beat(pick_word_char(), 1'b0);
      end else if (pick < 52) begin
        repeat ($urandom_range(1, 8)) send_beat(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
      end else if (pick < 62) begin
        send_beat(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 10)) send_beat(pick_text_byte(), 1'b0);
        r = $urandom_range(0, 19);
        if (r < 17) send_beat(CH_QUOTE, 1'b0);
        else if (r < 19) send_beat(CH_NUL, 1'b0);
      end else if (pick < 76) begin
        send_beat(pick_symbol(), 1'b0);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 3)) send_beat(pick_blank(), 1'b0);
      end else if (pick < 91) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 95) begin
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        case ($urandom_range(0, 3))
          0: send_beat(8'($urandom_range(0, 8)), 1'b0);
          1: send_beat(8'($urandom_range(14, 31)), 1'b0);
          2: send_beat(8'h7F, 1'b0);
          default: send_beat(8'($urandom_range(128, 255)), 1'b0);
        endcase
        repeat ($urandom_range(0, 4)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 1) == 0) send_beat(pick_blank(), 1'b0);
      if ($urandom_range(0, 150) == 0) wait_for_tokens();
    end
    wait_for_tokens();
  endtask

  initial begin
    for (int i = 9; i >= 0; i--)
      keyword_words[0] = $sformatf("%s%c", keyword_words[0], KW0_TEXT[8*i +: 8]);
    lex_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_adjacent_tokens();
    test_strings();
    test_terminators();
    test_long_tokens();
    test_random_stream();
    repeat (6) @(posedge clk);
    $display("sent %0d source beats (%0d live), checked %0d token records, %0d keywords",
             beats_sent, live_beats, tokens_checked, keywords_checked);
    $display("mismatched or unexpected records: %0d", bad_tokens);
    if (bad_tokens == 0 && pending_tokens.size() == 0) begin
      $display("streaming_keyword_lexer_top_test OK");
    end else begin
      $display("streaming_keyword_lexer_top_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
